FILE: design/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the bounded deque
// Request/response structs, opcode and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int OCC_W  = 8;
	localparam int GRP_SZ = 16;
	localparam int N_GRP  = (DEPTH + GRP_SZ - 1) / GRP_SZ;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_BACK  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_GATHER,
		S_COMMIT
	} state_t;

	typedef struct packed {
		op_t                      opcode;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		stat_t                    status;
		logic signed [WORD_W-1:0] popped_value;
		logic                     popped_valid;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	// per-cycle controls broadcast to every cell
	typedef struct packed {
		logic             push_front;
		logic             pop_front;
		logic             push_back;
		logic [IDX_W-1:0] wr_idx;
		logic [IDX_W-1:0] rd_idx;
	} cell_ctl_t;

	function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+OCC_W-1:0] wide;
		wide = {{OCC_W{1'b0}}, cnt};
		return wide[OCC_W-1:0];
	endfunction

endpackage

FILE: design/bounded_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue of signed 32-bit words, DEPTH entries
// Storage is a chain of cells with the front word always in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   A request (opcode + value) is taken on a rising edge with start high and
//   busy low. Opcodes: push front, pop front, push back, pop back.
//   Every request gives exactly one response on rsp, marked by done for a
//   single cycle. The response carries status (done / full / empty), the
//   popped word and its valid flag, and the occupancy after the request.
//   A new request is not taken while one is in flight. The cycle after accept
//   reads the addressed cell into the first level of the registered OR tree
//   (dq_gather); the next cycle finishes the tree, moves the cell chain and
//   loads the response register. busy falls while done is high, so the next
//   request can be taken in the same cycle its predecessor's response shows.
//   Push front shifts every cell one place toward the back; pop front shifts
//   one place toward the front; push back writes the cell at the count.
//   Reset (arst_n low) empties the queue at once; cell contents are left as
//   they are and never read before being written again.
//   The receiver has no way to stall: a response is gone after its cycle.
// ----------------------------------------------------------------------------
module bounded_deque
	import dq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	state_t           state_q, state_nxt;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             done_q;
	rsp_t             rsp_q;

	logic             gather_en;
	logic             commit;
	logic             accept;
	logic             is_push, is_full, is_empty, ok;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] tail_cnt;

	logic [DEPTH-1:0][WORD_W-1:0] cell_data;
	logic [DEPTH-1:0][WORD_W-1:0] cell_rd;
	logic signed [WORD_W-1:0]     gathered;

	assign accept = start && (state_q == S_IDLE);

	// ---------------- sequencer ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:   if (start) state_nxt = S_GATHER;
			S_GATHER: state_nxt = S_COMMIT;
			S_COMMIT: state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		gather_en = 1'b0;
		commit    = 1'b0;
		case (state_q)
			S_IDLE:   busy = 1'b0;
			S_GATHER: gather_en = 1'b1;
			S_COMMIT: commit = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	// ---------------- request decode ----------------
	assign is_push  = (req_q.opcode == OP_PUSH_FRONT) || (req_q.opcode == OP_PUSH_BACK);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign ok       = is_push ? !is_full : !is_empty;
	assign tail_cnt = count_q - CNT_W'(1);

	always_comb begin
		ctl.push_front = commit && ok && (req_q.opcode == OP_PUSH_FRONT);
		ctl.pop_front  = commit && ok && (req_q.opcode == OP_POP_FRONT);
		ctl.push_back  = commit && ok && (req_q.opcode == OP_PUSH_BACK);
		ctl.wr_idx     = count_q[IDX_W-1:0];
		// front word sits in cell 0, back word in cell count-1
		ctl.rd_idx     = (req_q.opcode == OP_POP_FRONT) ? '0 : tail_cnt[IDX_W-1:0];
	end

	always_comb begin
		count_nxt = count_q;
		if (ok) begin
			count_nxt = is_push ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
		end
	end

	// ---------------- cell chain ----------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w, right_w;
		if (i == 0) begin : g_head
			assign left_w = req_q.value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		dq_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  (left_w),
			.right_data (right_w),
			.wr_data    (req_q.value),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	dq_gather u_gather (
		.clk   (clk),
		.en    (gather_en),
		.words (cell_rd),
		.word  (gathered)
	);

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= commit;
			if (commit) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (commit) begin
			rsp_q.occupancy <= occ_of(count_nxt);
			if (ok) begin
				rsp_q.status       <= STAT_DONE;
				rsp_q.popped_valid <= !is_push;
				rsp_q.popped_value <= is_push ? '0 : gathered;
			end else begin
				rsp_q.status       <= is_push ? STAT_FULL : STAT_EMPTY;
				rsp_q.popped_valid <= 1'b0;
				rsp_q.popped_value <= '0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count exceeds capacity");

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> done)
		else $error("response missing after commit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> (count_q == $past(count_q)))
		else $error("count moved outside commit");

	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.popped_valid) |-> (rsp.status == STAT_DONE))
		else $error("popped word flagged on refused request");

endmodule

FILE: design/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the deque chain
// Holds one word; shifts toward either neighbor or loads the pushed word.
// ----------------------------------------------------------------------------
module dq_cell
	import dq_pkg::*;
(
	input  logic                     clk,
	input  logic [IDX_W-1:0]         idx,
	input  cell_ctl_t                ctl,
	input  logic signed [WORD_W-1:0] left_data,
	input  logic signed [WORD_W-1:0] right_data,
	input  logic signed [WORD_W-1:0] wr_data,
	output logic signed [WORD_W-1:0] data,
	output logic signed [WORD_W-1:0] rd_data
);

	logic signed [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_back && (idx == ctl.wr_idx)) begin
			data_q <= wr_data;
		end
	end

	assign data    = data_q;
	// only the addressed cell drives the gather tree
	assign rd_data = (idx == ctl.rd_idx) ? data_q : '0;

endmodule

FILE: design/dq_gather.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_gather: registered OR tree collecting the addressed cell word
// First level ORs groups of cells into registers, second level ORs groups.
// ----------------------------------------------------------------------------
module dq_gather
	import dq_pkg::*;
(
	input  logic                         clk,
	input  logic                         en,
	input  logic [DEPTH-1:0][WORD_W-1:0] words,
	output logic signed [WORD_W-1:0]     word
);

	logic [N_GRP-1:0][WORD_W-1:0] grp_or;
	logic [N_GRP-1:0][WORD_W-1:0] grp_q;

	for (genvar g = 0; g < N_GRP; g++) begin : g_grp
		logic [GRP_SZ-1:0][WORD_W-1:0] part;
		logic [WORD_W-1:0]             acc;
		for (genvar k = 0; k < GRP_SZ; k++) begin : g_leaf
			if (g * GRP_SZ + k < DEPTH) begin : g_real
				assign part[k] = words[g * GRP_SZ + k];
			end else begin : g_pad
				assign part[k] = '0;
			end
		end
		always_comb begin
			acc = '0;
			for (int k = 0; k < GRP_SZ; k++) begin
				acc = acc | part[k];
			end
		end
		assign grp_or[g] = acc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_q <= grp_or;
		end
	end

	always_comb begin
		word = '0;
		for (int g = 0; g < N_GRP; g++) begin
			word = word | grp_q[g];
		end
	end

endmodule

FILE: verif/bounded_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb: self-checking bench for the bounded deque
// Drives push/pop requests with random sender gaps and checks every response
// against an in-bench deque predictor, field by field, in request order.
// ----------------------------------------------------------------------------
module bounded_deque_tb;
	import dq_pkg::*;

	// Run shape
	localparam int RAND_REQS  = 1350;   // random requests after the directed list
	localparam int QUIET_LO   = 500;    // sender never idles in [QUIET_LO, QUIET_HI)
	localparam int QUIET_HI   = 800;
	localparam int DRAIN_AT_A = 300;    // sender waits for all responses here
	localparam int DRAIN_AT_B = 1000;
	localparam int IDLE_PCT   = 36;
	localparam int STALL_MAX  = 2000;   // cycles with no traffic before giving up
	localparam int TAIL_CYC   = 10;     // settle time after the last response
	localparam int PRINT_MAX  = 200;    // cap on printed mismatch lines

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	bounded_deque u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stimulus and scoreboard state
	req_t pending_req[$];     // requests not yet offered to the block
	rsp_t expected_rsp[$];    // predicted responses, oldest first
	int   sent_total = 0;     // requests accepted (driver only)
	int   got_total  = 0;     // responses seen (monitor only, nonblocking)
	int   errors     = 0;

	// Predictor copy of the deque
	logic signed [WORD_W-1:0] ring_words[DEPTH];
	int front_pos = 0;
	int held      = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < PRINT_MAX) begin
			$display("[%0t] MISMATCH %s: got %08h want %08h (response %0d)",
				$realtime, what, got, want, got_total);
		end
		errors++;
	endtask

	// Apply one request to the predictor and return the response it must give.
	task automatic predict_response(input req_t r, output rsp_t e);
		e        = '0;
		e.status = STAT_DONE;
		case (r.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (held >= DEPTH) begin
					e.status = STAT_FULL;    // refused, nothing stored
				end else if (r.opcode == OP_PUSH_FRONT) begin
					front_pos = (front_pos + DEPTH - 1) % DEPTH;
					ring_words[front_pos] = r.value;
					held++;
				end else begin
					ring_words[(front_pos + held) % DEPTH] = r.value;
					held++;
				end
			end
			default: begin
				if (held == 0) begin
					e.status = STAT_EMPTY;   // refused, state unchanged
				end else if (r.opcode == OP_POP_FRONT) begin
					e.popped_value = ring_words[front_pos];
					e.popped_valid = 1'b1;
					front_pos = (front_pos + 1) % DEPTH;
					held--;
				end else begin
					e.popped_value = ring_words[(front_pos + held - 1) % DEPTH];
					e.popped_valid = 1'b1;
					held--;
				end
			end
		endcase
		// occupancy reports the low bits of the count
		e.occupancy = OCC_W'(held);
	endtask

	function automatic void queue_req(input op_t op, input logic [WORD_W-1:0] v);
		req_t r;
		r.opcode = op;
		r.value  = v;
		pending_req.push_back(r);
	endfunction

	// Driver: offers the next pending request, holds it while busy, records the
	// prediction on the accepting edge. Idles at random except in the quiet
	// stretch, and stops twice until every outstanding response has come back.
	always @(posedge clk) begin : drive
		req_t fresh;
		rsp_t want;
		bit   gap;
		bit   drain_wait;
		if (arst_n) begin
			if (start && !busy) begin
				predict_response(req, want);
				expected_rsp.push_back(want);
				sent_total++;
			end
			if (!(start && busy)) begin
				gap = ($urandom_range(99) < IDLE_PCT)
					&& !(sent_total >= QUIET_LO && sent_total < QUIET_HI);
				drain_wait = (sent_total == DRAIN_AT_A || sent_total == DRAIN_AT_B)
					&& (got_total != sent_total);
				if (pending_req.size() != 0 && !gap && !drain_wait) begin
					fresh = pending_req.pop_front();
					req   <= fresh;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed response must match the oldest prediction.
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n && done) begin
			got_total <= got_total + 1;
			if (expected_rsp.size() == 0) begin
				report_mismatch("response with no request", rsp.popped_value, '0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.popped_value !== want.popped_value)
					report_mismatch("popped_value", rsp.popped_value, want.popped_value);
				if (rsp.popped_valid !== want.popped_valid)
					report_mismatch("popped_valid", rsp.popped_valid, want.popped_valid);
				if (rsp.occupancy !== want.occupancy)
					report_mismatch("occupancy", rsp.occupancy, want.occupancy);
			end
		end
	end

	// Watchdog: a run of cycles with neither an accept nor a response is a hang.
	always @(posedge clk) begin : dog
		int stall_cyc;
		if (!arst_n || (start && !busy) || done) begin
			stall_cyc = 0;
		end else begin
			stall_cyc++;
			if (stall_cyc >= STALL_MAX) begin
				$display("[%0t] no traffic for %0d cycles", $realtime, stall_cyc);
				$display("bounded_deque_tb failed");
				$finish;
			end
		end
	end

	initial begin : stim
		int  gen_count;
		bit  filling;
		bit  is_push;
		bit  at_front;
		op_t op;
		logic [WORD_W-1:0] v;

		// Directed: refused pops, extremes, front push on empty, cross-end pops
		queue_req(OP_POP_FRONT,  32'h0000_0000);   // empty
		queue_req(OP_POP_BACK,   32'hFFFF_FFFF);   // empty
		queue_req(OP_PUSH_FRONT, 32'h7FFF_FFFF);   // front push on empty
		queue_req(OP_PUSH_BACK,  32'h8000_0000);
		queue_req(OP_PUSH_FRONT, 32'h0000_0000);
		queue_req(OP_PUSH_BACK,  32'hFFFF_FFFF);
		queue_req(OP_POP_FRONT,  32'h1234_5678);
		queue_req(OP_POP_BACK,   32'h8765_4321);
		queue_req(OP_POP_FRONT,  32'h0000_0000);
		queue_req(OP_POP_BACK,   32'h0000_0000);
		queue_req(OP_POP_BACK,   32'h0000_0000);   // empty again
		queue_req(OP_PUSH_BACK,  32'h5555_5555);
		queue_req(OP_POP_FRONT,  32'h0000_0000);   // back push, front pop
		queue_req(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		queue_req(OP_POP_BACK,   32'h0000_0000);   // front push, back pop
		queue_req(OP_PUSH_FRONT, 32'h0000_0001);
		queue_req(OP_PUSH_FRONT, 32'h0000_0002);
		queue_req(OP_PUSH_BACK,  32'h0000_0003);
		queue_req(OP_POP_FRONT,  32'h0000_0000);
		queue_req(OP_POP_FRONT,  32'h0000_0000);
		queue_req(OP_POP_FRONT,  32'h0000_0000);
		queue_req(OP_POP_FRONT,  32'h0000_0000);   // empty

		// Random: alternate push-heavy and pop-heavy phases so the queue swings
		// between empty and full, lingering a few requests at each end.
		gen_count = 0;
		filling   = 1'b1;
		for (int i = 0; i < RAND_REQS; i++) begin
			is_push  = $urandom_range(99) < (filling ? 75 : 25);
			at_front = $urandom_range(1);
			if (is_push)
				op = at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = at_front ? OP_POP_FRONT : OP_POP_BACK;
			case ($urandom_range(15))
				0:       v = 32'h8000_0000;
				1:       v = 32'h7FFF_FFFF;
				2:       v = 32'h0000_0000;
				3:       v = 32'hFFFF_FFFF;
				default: v = $urandom;
			endcase
			queue_req(op, v);
			if (is_push && gen_count < DEPTH)
				gen_count++;
			else if (!is_push && gen_count > 0)
				gen_count--;
			if (gen_count == DEPTH && $urandom_range(7) == 0)
				filling = 1'b0;
			else if (gen_count == 0 && $urandom_range(7) == 0)
				filling = 1'b1;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge so the clocked blocks have settled.
		do @(negedge clk);
		while (pending_req.size() != 0 || start || got_total != sent_total);
		repeat (TAIL_CYC) @(negedge clk);

		if (expected_rsp.size() != 0)
			report_mismatch("responses never seen", expected_rsp.size(), 0);

		if (errors == 0) begin
			$display("bounded_deque_tb passed");
		end else begin
			$display("bounded_deque_tb failed");
		end
		$finish;
	end

endmodule

FILE: bounded_deque.f
design/dq_pkg.sv
design/dq_cell.sv
design/dq_gather.sv
design/bounded_deque.sv
verif/bounded_deque_tb.sv
